// ----- hw/rtl/aes_pkg.sv -----
// AES-128 package: payload types, S-box function, GF(2^8) helpers.
// Used by every file of the aes128_block_encrypt block.
`default_nettype none
package aes_pkg;

  localparam int unsigned RoundsDef = 10;
  localparam int unsigned KeyWords  = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned WordW     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_WORD_0 = 2'd0,
    REG_KEY_WORD_1 = 2'd1,
    REG_KEY_WORD_2 = 2'd2,
    REG_KEY_WORD_3 = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] plain_word_0;
    logic [31:0] plain_word_1;
    logic [31:0] plain_word_2;
    logic [31:0] plain_word_3;
  } plain_t;

  typedef struct packed {
    logic [31:0] cipher_word_0;
    logic [31:0] cipher_word_1;
    logic [31:0] cipher_word_2;
    logic [31:0] cipher_word_3;
  } cipher_t;

  // one round's worth of key, word 0 in the top bits
  typedef logic [127:0] rkey_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Next round key from the previous one; rc is that round's constant.
  function automatic rkey_t next_rkey(input rkey_t k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    next_rkey = {w0, w1, w2, w3};
  endfunction

  // SubBytes + ShiftRows, optionally MixColumns; column c in word c.
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int rw = 0; rw < 4; rw++)
        t[c*4+rw] = SBOX[b[((c + rw) % 4) * 4 + rw]];
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (mix) begin
        t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    round_fn = r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/aes_key_cell.sv -----
// One key-schedule cell: registers one round key derived from its neighbor.
// Depends on aes_pkg.
`default_nettype none
module aes_key_cell #(
  parameter logic [7:0] Rcon = 8'h01
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  aes_pkg::rkey_t  key_i,
  output aes_pkg::rkey_t  key_o
);
  aes_pkg::rkey_t key_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= aes_pkg::next_rkey(key_i, Rcon);
    end
  end
  assign key_o = key_q;
endmodule
`default_nettype wire

// ----- hw/rtl/aes_round_cell.sv -----
// One cipher round cell: round function plus key add, state handed on each cycle.
// Depends on aes_pkg.
`default_nettype none
module aes_round_cell #(
  parameter bit Mix = 1'b1
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              valid_i,
  input  wire [127:0]      state_i,
  input  aes_pkg::rkey_t   key_i,
  output logic             valid_o,
  output logic [127:0]     state_o
);
  logic         valid_q;
  logic [127:0] state_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    state_q <= aes_pkg::round_fn(state_i, Mix) ^ key_i;
  end
  assign valid_o = valid_q;
  assign state_o = state_q;
endmodule
`default_nettype wire

// ----- hw/rtl/aes128_block_encrypt.sv -----
// AES-128 encryption top level: key registers, key cell chain, round cell chain.
// Depends on aes_pkg, aes_key_cell, aes_round_cell.
`default_nettype none
// One block is accepted in every cycle (busy stays low). Its ciphertext appears
// with done_o after the accepting edge: one register whitens the input, then each
// of the Rounds round cells registers one round. The key schedule is a chain of
// key cells in lockstep with the round cells, so round key r reaches cell r exactly
// when the item does. A key write applies to every item accepted after it, without
// draining the pipeline first; items already in flight finish with the old key.
// The receiver cannot stall: results must be taken the cycle they appear.
module aes128_block_encrypt #(
  parameter int unsigned Rounds = aes_pkg::RoundsDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  aes_pkg::plain_t                plain_i,
  output logic                           done_o,
  output aes_pkg::cipher_t               cipher_o,
  input  wire                            cfg_we_i,
  input  wire [aes_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire [aes_pkg::WordW-1:0]       cfg_data_i
);
  localparam logic [7:0] RCON [10] =
    '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  logic [31:0] key_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (aes_pkg::cfg_reg_e'(cfg_idx_i))
        aes_pkg::REG_KEY_WORD_0: key_q[0] <= cfg_data_i;
        aes_pkg::REG_KEY_WORD_1: key_q[1] <= cfg_data_i;
        aes_pkg::REG_KEY_WORD_2: key_q[2] <= cfg_data_i;
        aes_pkg::REG_KEY_WORD_3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // key chain: rk[r] is the key delivered at stage r, aligned with the state
  aes_pkg::rkey_t rk [Rounds+1];
  aes_pkg::rkey_t k0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) k0_q <= '0;
    else         k0_q <= {key_q[0], key_q[1], key_q[2], key_q[3]};
  end
  // rk[0] feeds the whitening stage; k0_q and then each key cell add one register behind it
  assign rk[0] = {key_q[0], key_q[1], key_q[2], key_q[3]};

  aes_pkg::rkey_t kc [Rounds];
  assign kc[0] = k0_q;
  logic [127:0] st [Rounds+1];
  logic         vl [Rounds+1];

  logic         v0_q;
  logic [127:0] s0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= start;
  end
  always_ff @(posedge clk_i) s0_q <= plain_i ^ rk[0];
  assign st[0] = s0_q;
  assign vl[0] = v0_q;

  for (genvar r = 1; r <= Rounds; r++) begin : g_round
    // key cell r registers key r from key r-1 held in kc[r-1]; the round
    // cell r needs key r combinationally while it holds st[r-1], so derive it here
    if (r < Rounds) begin : g_key
      aes_key_cell #(.Rcon(RCON[(r-1) % 10])) u_key (
        .clk_i(clk_i), .rst_ni(rst_ni), .key_i(kc[r-1]), .key_o(kc[r]));
    end
    assign rk[r] = aes_pkg::next_rkey(kc[r-1], RCON[(r-1) % 10]);
    aes_round_cell #(.Mix(r != Rounds)) u_round (
      .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(vl[r-1]), .state_i(st[r-1]),
      .key_i(rk[r]), .valid_o(vl[r]), .state_o(st[r]));
  end

  assign busy     = 1'b0;
  assign done_o   = vl[Rounds];
  assign cipher_o = st[Rounds];

  // a result must trace back to an accepted item
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Rounds + 1))
    else $error("done without source");
  a_v0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> vl[0]) else $error("start not captured");
  a_v1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vl[0] |=> vl[1]) else $error("valid lost in chain");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");
endmodule
`default_nettype wire

// ----- sim/aes128_block_encrypt_tb.sv -----
// Self-checking testbench for aes128_block_encrypt: AES-128 block encryption.
// Depends on aes_pkg and the aes128_block_encrypt RTL; checks every block against
// a cipher model held in the bench.
`timescale 1ns / 1ps
module aes128_block_encrypt_tb;

  localparam int unsigned Latency  = aes_pkg::RoundsDef + 1;
  localparam int unsigned IdleMax  = 14;
  localparam int unsigned Watchdog = 2000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  aes_pkg::plain_t             plain_i = '0;
  logic                        done_o;
  aes_pkg::cipher_t            cipher_o;
  logic                        cfg_we_i = 1'b0;
  logic [aes_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [aes_pkg::WordW-1:0]   cfg_data_i = '0;

  aes128_block_encrypt i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .plain_i   (plain_i),
    .done_o    (done_o),
    .cipher_o  (cipher_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial forever #5 clk_i = ~clk_i;

  // bench copy of the key and its 44-word schedule
  logic [31:0]      key_q [4];
  logic [31:0]      sched_q [44];
  aes_pkg::cipher_t cipher_q [$];
  int               mismatches = 0;
  int               stall_cycles = 0;
  bit               timed_out = 1'b0;

  function automatic logic [7:0] gf_dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {aes_pkg::SBOX[w[31:24]], aes_pkg::SBOX[w[23:16]],
            aes_pkg::SBOX[w[15:8]], aes_pkg::SBOX[w[7:0]]};
  endfunction

  function automatic void expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) sched_q[i] = key_q[i];
    for (int i = 4; i < 44; i++) begin
      t = sched_q[i-1];
      if (i % 4 == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end
      sched_q[i] = sched_q[i-4] ^ t;
    end
  endfunction

  function automatic aes_pkg::cipher_t encrypt_block(input aes_pkg::plain_t p);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [31:0] w;
    aes_pkg::cipher_t res;
    for (int c = 0; c < 4; c++) begin
      w = p[127-32*c -: 32] ^ sched_q[c];
      for (int r = 0; r < 4; r++) st[c*4+r] = w[31-8*r -: 8];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          tmp[c*4+r] = aes_pkg::SBOX[st[((c + r) % 4)*4 + r]];
      for (int c = 0; c < 4; c++) begin
        a0 = tmp[c*4]; a1 = tmp[c*4+1]; a2 = tmp[c*4+2]; a3 = tmp[c*4+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        if (rnd < 10) begin
          tmp[c*4]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
          tmp[c*4+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
          tmp[c*4+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
          tmp[c*4+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
        end
        w = sched_q[4*rnd+c];
        for (int r = 0; r < 4; r++) st[c*4+r] = tmp[c*4+r] ^ w[31-8*r -: 8];
      end
    end
    for (int c = 0; c < 4; c++)
      res[127-32*c -: 32] = {st[c*4], st[c*4+1], st[c*4+2], st[c*4+3]};
    return res;
  endfunction

  // result checker and watchdog
  always @(posedge clk_i) begin
    aes_pkg::cipher_t exp_c;
    if (rst_ni && done_o) begin
      if (cipher_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", cipher_o);
      end else begin
        exp_c = cipher_q.pop_front();
        if (cipher_o !== exp_c) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch w0 exp %h got %h", exp_c.cipher_word_0, cipher_o.cipher_word_0);
            $display("mismatch w1 exp %h got %h", exp_c.cipher_word_1, cipher_o.cipher_word_1);
            $display("mismatch w2 exp %h got %h", exp_c.cipher_word_2, cipher_o.cipher_word_2);
            $display("mismatch w3 exp %h got %h", exp_c.cipher_word_3, cipher_o.cipher_word_3);
          end
        end
      end
    end
    if ((start && !busy) || done_o) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= Watchdog && !timed_out) begin
      timed_out = 1'b1;
      $display("aes128_block_encrypt_tb: errors");
      $finish;
    end
  end

  task automatic send_block(input aes_pkg::plain_t p, input bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(IdleMax, 0) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start   <= 1'b1;
    plain_i <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cipher_q.push_back(encrypt_block(p));
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (cipher_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 2) @(negedge clk_i);
  endtask

  task automatic write_key_reg(input aes_pkg::cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    key_q[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    expand_schedule();
    // key chain refill
    repeat (Latency + 1) @(negedge clk_i);
  endtask

  task automatic load_key(input logic [127:0] k);
    write_key_reg(aes_pkg::REG_KEY_WORD_0, k[127:96]);
    write_key_reg(aes_pkg::REG_KEY_WORD_1, k[95:64]);
    write_key_reg(aes_pkg::REG_KEY_WORD_2, k[63:32]);
    write_key_reg(aes_pkg::REG_KEY_WORD_3, k[31:0]);
  endtask

  function automatic aes_pkg::plain_t rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic test_reset_key();
    // schedule of the all-zero key after reset
    send_block('0, 0);
    send_block('1, 0);
    drain();
  endtask

  task automatic test_known_vector();
    load_key(128'h000102030405060708090a0b0c0d0e0f);
    send_block(128'h00112233445566778899aabbccddeeff, 0);
    drain();
    load_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
    send_block(128'h3243f6a8885a308d313198a2e0370734, 0);
    drain();
  endtask

  task automatic test_extremes();
    load_key('1);
    send_block('0, 0);
    send_block('1, 0);
    send_block({4{32'h80000000}}, 0);
    send_block({4{32'h00000001}}, 0);
    send_block({32'hffffffff, 32'h0, 32'hffffffff, 32'h0}, 0);
    drain();
    load_key('0);
    send_block('1, 0);
    send_block(128'h0000000100000001_0000000100000001, 0);
    drain();
  endtask

  task automatic test_random(input int phases, input int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      load_key({$urandom, $urandom, $urandom, $urandom});
      for (int n = 0; n < per_phase; n++)
        // every third phase sends without gaps; the other phases allow random gaps
        send_block(rand_block(), (ph % 3) != 0);
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) key_q[i] = '0;
    expand_schedule();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_key();
    test_known_vector();
    test_extremes();
    test_random(10, 155);
    if (mismatches == 0 && cipher_q.size() == 0)
      $display("aes128_block_encrypt_tb: clean");
    else
      $display("aes128_block_encrypt_tb: errors");
    $finish;
  end
endmodule
